>>> hw/rtl/scpr_pkg.sv
package scpr_pkg;

  // field widths
  localparam int unsigned PAGE_BITS   = 20;
  localparam int unsigned FAULT_BITS  = 32;
  localparam int unsigned FRAMES_BITS = 5;

  // default store depth and frame limit after reset
  localparam int unsigned           MAX_FRAMES   = 16;
  localparam logic [FRAMES_BITS-1:0] FRAMES_RESET = 5'd4;

  typedef struct packed {
    logic                 new_run;
    logic [PAGE_BITS-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic                  page_fault;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_BITS-1:0] fault_count;
  } rsp_t;

endpackage

>>> hw/rtl/scpr_ram.sv
module scpr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/second_chance_page_replacement.sv
// second-chance page replacement over a small resident set
//
// input channel: a word on req_i (new_run, page_number) is taken at a clock edge
// where start is high and busy is low. one result word leaves on res_o,
// marked by a one-cycle done_o strobe; the receiver cannot hold it off,
// so the block never waits on the output side
// config channel: cfg_data_i (frames_in_use) is written when cfg_valid_i and
// cfg_ready_o are both high; ready is high whenever the block is idle
//
// operation: the resident pages sit in one memory with a registered read,
// swept one entry per cycle
//   hit:               pipelined compare sweep
//   miss with room:    sweep, then tail write
//   miss with full set: sweep, then the victim sweep clears bits
//                      and shifts the younger pages down in one pass, and
//                      wraps once when every bit was set
// done_o is high in the first cycle with busy low; the next word can be
// started in the cycle done_o is high
//
// reset empties the resident set, zeroes the fault count and sets the frame
// limit to four; memory contents are not cleared, only occupied entries are read
module second_chance_page_replacement import scpr_pkg::*; #(
  parameter int unsigned MaxFrames = MAX_FRAMES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  req_t                   req_i,
  // result channel
  output logic                   done_o,
  output rsp_t                   res_o,
  // frame limit register
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [FRAMES_BITS-1:0] cfg_data_i
);

  localparam int unsigned IdxBits = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned CntBits = $clog2(MaxFrames + 1);
  localparam int unsigned LimBits = (CntBits > FRAMES_BITS) ? CntBits : FRAMES_BITS;

  // one memory entry: reference bit on top of the page number
  typedef struct packed {
    logic                 refb;
    logic [PAGE_BITS-1:0] page;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_TAIL   = 2'd3;

  // control state
  logic [1:0]            state_q, state_d;
  logic [CntBits-1:0]    occ_q, occ_d;        // resident page count
  logic [FAULT_BITS-1:0] faults_q, faults_d;  // faults since last new run
  logic [FRAMES_BITS-1:0] cfg_q, cfg_d;       // frames_in_use
  logic [CntBits-1:0]    cnt_q, cnt_d;        // read sweep address
  logic                  dv_q, dv_d;          // read data in flight
  logic                  dpass_q, dpass_d;    // pass tag of data in flight
  logic                  ipass_q, ipass_d;    // pass of the read sweep
  logic                  idone_q, idone_d;    // read sweep finished
  logic                  vf_q, vf_d;          // victim found
  logic                  vpass_q, vpass_d;    // pass in which the victim was found
  logic                  done_q, done_d;

  // payload
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [PAGE_BITS-1:0]  evict_q, evict_d;
  logic [IdxBits-1:0]    didx_q, didx_d;      // index of data in flight
  logic [IdxBits-1:0]    tail_q, tail_d;      // where the new page goes
  rsp_t                  res_q, res_d;

  // memory port
  logic                  ram_we;
  logic [IdxBits-1:0]    ram_waddr;
  entry_t                ram_wdata;
  logic [IdxBits-1:0]    ram_raddr;
  logic [EntryBits-1:0]  ram_rdata;
  entry_t                rd_entry;

  logic [LimBits-1:0]    lim;
  logic                  room;
  logic [CntBits-1:0]    last;
  logic                  issue;
  logic                  hit;
  logic                  data_last;
  logic [FAULT_BITS-1:0] faults_inc;

  assign rd_entry = entry_t'(ram_rdata);

  // effective frame limit: zero acts as one, clamp to the store depth
  always_comb begin
    lim = LimBits'(cfg_q);
    if (cfg_q == '0) begin
      lim = LimBits'(1);
    end
    if (lim > LimBits'(MaxFrames)) begin
      lim = LimBits'(MaxFrames);
    end
  end

  assign room       = LimBits'(occ_q) < lim;
  assign last       = occ_q - CntBits'(1);
  assign data_last  = CntBits'(didx_q) == last;
  assign faults_inc = (&faults_q) ? faults_q : faults_q + FAULT_BITS'(1);

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    faults_d  = faults_q;
    cfg_d     = cfg_q;
    cnt_d     = cnt_q;
    dv_d      = 1'b0;
    dpass_d   = dpass_q;
    ipass_d   = ipass_q;
    idone_d   = idone_q;
    vf_d      = vf_q;
    vpass_d   = vpass_q;
    done_d    = 1'b0;
    page_d    = page_q;
    evict_d   = evict_q;
    didx_d    = didx_q;
    tail_d    = tail_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = didx_q;
    ram_wdata = rd_entry;
    ram_raddr = cnt_q[IdxBits-1:0];
    issue     = 1'b0;
    hit       = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          page_d  = req_i.page_number;
          cnt_d   = '0;
          state_d = ST_SEARCH;
          if (req_i.new_run) begin
            occ_d    = '0;
            faults_d = '0;
          end
        end
      end

      // pipelined compare sweep over the occupied entries
      ST_SEARCH: begin
        issue = cnt_q < occ_q;
        hit   = dv_q && (rd_entry.page == page_q);
        if (issue) begin
          cnt_d  = cnt_q + CntBits'(1);
          dv_d   = 1'b1;
          didx_d = cnt_q[IdxBits-1:0];
        end
        if (hit) begin
          // set the reference bit in place
          ram_we    = 1'b1;
          ram_waddr = didx_q;
          ram_wdata = '{refb: 1'b1, page: page_q};
          done_d    = 1'b1;
          res_d     = '{page_fault: 1'b0, evicted_valid: 1'b0,
                        evicted_page: '0, fault_count: faults_q};
          dv_d      = 1'b0;
          state_d   = ST_IDLE;
        end else if (!issue) begin
          // miss
          faults_d = faults_inc;
          vf_d     = 1'b0;
          dv_d     = 1'b0;
          if (room) begin
            tail_d  = occ_q[IdxBits-1:0];
            occ_d   = occ_q + CntBits'(1);
            state_d = ST_TAIL;
          end else begin
            tail_d  = last[IdxBits-1:0];
            cnt_d   = '0;
            ipass_d = 1'b0;
            idone_d = 1'b0;
            vpass_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end

      // victim sweep: clear set bits ahead of the victim, shift the rest down
      ST_SCAN: begin
        if (!idone_q) begin
          dv_d    = 1'b1;
          didx_d  = cnt_q[IdxBits-1:0];
          dpass_d = ipass_q;
          if (cnt_q == last) begin
            cnt_d = '0;
            if (ipass_q) begin
              idone_d = 1'b1;
            end else begin
              ipass_d = 1'b1;
            end
          end else begin
            cnt_d = cnt_q + CntBits'(1);
          end
        end
        if (dv_q) begin
          if (!vf_q) begin
            // on the second pass every bit is already clear
            if (rd_entry.refb && !dpass_q) begin
              ram_we    = 1'b1;
              ram_waddr = didx_q;
              ram_wdata = '{refb: 1'b0, page: rd_entry.page};
            end else begin
              vf_d    = 1'b1;
              vpass_d = dpass_q;
              evict_d = rd_entry.page;
              if (data_last) begin
                state_d = ST_TAIL;
              end
            end
          end else if (dpass_q == vpass_q) begin
            ram_we    = 1'b1;
            ram_waddr = didx_q - IdxBits'(1);
            ram_wdata = rd_entry;
            if (data_last) begin
              state_d = ST_TAIL;
            end
          end
        end
      end

      ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = tail_q;
        ram_wdata = '{refb: 1'b0, page: page_q};
        done_d    = 1'b1;
        res_d     = '{page_fault: 1'b1, evicted_valid: vf_q,
                      evicted_page: vf_q ? evict_q : '0, fault_count: faults_q};
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      occ_q    <= '0;
      faults_q <= '0;
      cfg_q    <= FRAMES_RESET;
      cnt_q    <= '0;
      dv_q     <= 1'b0;
      dpass_q  <= 1'b0;
      ipass_q  <= 1'b0;
      idone_q  <= 1'b0;
      vf_q     <= 1'b0;
      vpass_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      faults_q <= faults_d;
      cfg_q    <= cfg_d;
      cnt_q    <= cnt_d;
      dv_q     <= dv_d;
      dpass_q  <= dpass_d;
      ipass_q  <= ipass_d;
      idone_q  <= idone_d;
      vf_q     <= vf_d;
      vpass_q  <= vpass_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    evict_q <= evict_d;
    didx_q  <= didx_d;
    tail_q  <= tail_d;
    res_q   <= res_d;
  end

  // page store
  scpr_ram #(
    .Width (EntryBits),
    .Depth (MaxFrames)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy        = state_q != ST_IDLE;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign done_o      = done_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // occupancy never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntBits'(MaxFrames))
    else $error("occupancy above store depth");

  // the victim sweep only runs over a non-empty set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (occ_q != '0))
    else $error("victim sweep on an empty set");

  // a result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q != ST_IDLE))
    else $error("result without work");

  // nothing writes the store while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("store write while idle");

  // a miss ending in eviction leaves the set as full as before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL && vf_q) |=> $stable(occ_q))
    else $error("eviction changed occupancy");
`endif

endmodule

>>> bench/second_chance_page_replacement_tb.sv
`timescale 1ns / 100ps

module second_chance_page_replacement_tb;
  import scpr_pkg::*;

  // clock, reset and block ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  req_t                   req_i;
  logic                   done_o;
  rsp_t                   res_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [FRAMES_BITS-1:0] cfg_data_i;

  // 4 ns period, two delays
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  second_chance_page_replacement dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the resident set, kept in arrival order, oldest at index 0
  logic [PAGE_BITS-1:0]   frame_pages [MAX_FRAMES];
  bit                     ref_bits    [MAX_FRAMES];
  int unsigned            frames_occupied;
  logic [FAULT_BITS-1:0]  fault_total;
  logic [FRAMES_BITS-1:0] frame_limit_reg;

  // predicted result words, oldest first
  rsp_t predicted_outcomes[$];
  int   mismatch_count;

  // when set the sender skips its random pauses
  bit   no_idle;

  // works out the result word of one reference and advances the shadow set
  function automatic rsp_t predict_reference(req_t r);
    rsp_t        w;
    int unsigned lim;
    int unsigned n;
    int unsigned victim;
    bit          hit;
    bit          found;
    w = '0;
    // new run empties the set and the count before the lookup
    if (r.new_run) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_pages[i] = '0;
        ref_bits[i]    = 1'b0;
      end
      frames_occupied = 0;
      fault_total     = '0;
    end
    // zero acts as one frame, anything above the store depth as the depth
    lim = 32'(frame_limit_reg);
    if (lim < 1) lim = 1;
    if (lim > MAX_FRAMES) lim = MAX_FRAMES;
    n = frames_occupied;
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!hit && frame_pages[i] == r.page_number) begin
        ref_bits[i] = 1'b1;
        hit = 1'b1;
      end
    end
    if (hit) begin
      w.fault_count = fault_total;
      return w;
    end
    // miss: count saturates at all ones
    if (fault_total != '1) fault_total = fault_total + 1'b1;
    w.page_fault = 1'b1;
    if (n < lim) begin
      // free room, append at the tail
      frame_pages[n]  = r.page_number;
      ref_bits[n]     = 1'b0;
      frames_occupied = n + 1;
    end else begin
      // full (or limit lowered below occupancy): clear set bits from the
      // oldest until a clear one; if all were set the oldest goes
      victim = 0;
      found  = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!found) begin
          if (!ref_bits[i]) begin
            victim = i;
            found  = 1'b1;
          end else begin
            ref_bits[i] = 1'b0;
          end
        end
      end
      w.evicted_valid = 1'b1;
      w.evicted_page  = frame_pages[victim];
      for (int i = victim; i + 1 < n; i++) begin
        frame_pages[i] = frame_pages[i+1];
        ref_bits[i]    = ref_bits[i+1];
      end
      frame_pages[n-1] = r.page_number;
      ref_bits[n-1]    = 1'b0;
    end
    w.fault_count = fault_total;
    return w;
  endfunction

  // one word on the command channel; start is left high after acceptance so
  // that back-to-back words need only one assignment per falling edge
  task automatic send_reference(input bit run, input logic [PAGE_BITS-1:0] page);
    req_t r;
    r.new_run     = run;
    r.page_number = page;
    @(negedge clk_i);
    // pauses only count once the block could take a word
    while (busy) @(negedge clk_i);
    // random pauses, each about 29 in a hundred; garbage on the bus meanwhile
    while (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      req_i <= req_t'($urandom);
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted_outcomes.push_back(predict_reference(r));
  endtask

  // lower start and hold off until every predicted word has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // frame limit write, only with the block idle
  task automatic set_frames(input logic [FRAMES_BITS-1:0] frames);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= frames;
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_limit_reg = frames;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= FRAMES_BITS'($urandom);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatch_count < 10)
      $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // result checker: every done strobe pops the oldest prediction
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && done_o) begin
      if (predicted_outcomes.size() == 0) begin
        note_mismatch("unexpected word", '0, res_o.fault_count);
      end else begin
        want = predicted_outcomes.pop_front();
        if (res_o.page_fault !== want.page_fault)
          note_mismatch("page_fault", 32'(want.page_fault), 32'(res_o.page_fault));
        if (res_o.evicted_valid !== want.evicted_valid)
          note_mismatch("evicted_valid", 32'(want.evicted_valid),
                        32'(res_o.evicted_valid));
        if (res_o.evicted_page !== want.evicted_page)
          note_mismatch("evicted_page", 32'(want.evicted_page),
                        32'(res_o.evicted_page));
        if (res_o.fault_count !== want.fault_count)
          note_mismatch("fault_count", want.fault_count, res_o.fault_count);
      end
    end
  end

  // reset limit of four: fill with the page extremes, reference every page
  // so all bits are set, then a miss must wrap and evict the oldest
  task automatic test_reset_limit_wrap();
    send_reference(1'b1, '0);
    send_reference(1'b0, '1);
    send_reference(1'b0, 20'h00001);
    send_reference(1'b0, 20'h00002);
    send_reference(1'b0, '0);
    send_reference(1'b0, '1);
    send_reference(1'b0, 20'h00001);
    send_reference(1'b0, 20'h00002);
    send_reference(1'b0, 20'h00003);
  endtask

  // limit of zero behaves as a single frame
  task automatic test_zero_limit();
    set_frames('0);
    send_reference(1'b1, 20'hA5A5A);
    send_reference(1'b0, 20'h5A5A5);
    send_reference(1'b0, 20'h5A5A5);
  endtask

  // limit lowered below occupancy: set counts as full and stays that size
  task automatic test_limit_below_occupancy();
    set_frames(5'd8);
    send_reference(1'b1, 20'h10000);
    for (int i = 1; i < 6; i++) send_reference(1'b0, PAGE_BITS'(20'h10000 + i));
    set_frames(5'd2);
    send_reference(1'b0, 20'h10001);
    send_reference(1'b0, 20'hF0000);
    send_reference(1'b0, 20'hF0001);
  endtask

  // random references at one frame limit: mostly a small working set a bit
  // larger than the limit so hits, set bits and evictions mix, the rest
  // anywhere in the page space, now and then a new run or a full drain
  task automatic run_random_phase(input logic [FRAMES_BITS-1:0] frames,
                                  input int count);
    logic [PAGE_BITS-1:0] base;
    int unsigned          pool;
    logic [PAGE_BITS-1:0] page;
    bit                   run;
    set_frames(frames);
    base = PAGE_BITS'($urandom);
    pool = ((frames == 0) ? 1 : (frames > MAX_FRAMES ? MAX_FRAMES : frames))
           + 2 + $urandom_range(3);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 80)
        page = base ^ PAGE_BITS'($urandom_range(pool - 1));
      else
        page = PAGE_BITS'($urandom);
      run = ($urandom_range(99) < 3);
      send_reference(run, page);
      // sender pause until everything is back
      if ($urandom_range(59) == 0) wait_drained();
    end
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("[second_chance_page_replacement] ERROR");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    mismatch_count  = 0;
    frames_occupied = 0;
    fault_total     = '0;
    frame_limit_reg = FRAMES_RESET;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      frame_pages[i] = '0;
      ref_bits[i]    = 1'b0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_limit_wrap();
    test_zero_limit();
    test_limit_below_occupancy();

    run_random_phase(5'd4, 80);
    run_random_phase(5'd1, 50);
    // long stretch without random pauses at the full store depth
    no_idle = 1'b1;
    run_random_phase(5'd16, 100);
    no_idle = 1'b0;
    run_random_phase(5'd31, 60);
    run_random_phase(5'd0, 30);
    run_random_phase(5'd9, 80);
    run_random_phase(5'd17, 50);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
      $display("[second_chance_page_replacement] OK");
    end else begin
      $display("[second_chance_page_replacement] ERROR");
    end
    $finish;
  end

endmodule
